FILE: sv/fixed_slot_allocator_unit_macros.svh
// Assertion macros for the fixed slot allocator unit.
`ifndef FIXED_SLOT_ALLOCATOR_UNIT_MACROS_SVH
`define FIXED_SLOT_ALLOCATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define FSA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define FSA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`else

`define FSA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define FSA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: sv/fsa_pkg.sv
// Shared types, widths and codes for the fixed slot allocator.
package fsa_pkg;

	localparam int SLOTS_DEFAULT = 1024;

	localparam int KIND_W   = 2;
	localparam int SLOT_W   = 10;
	localparam int CNT_W    = 11;
	localparam int STATUS_W = 2;
	localparam int ADDR_W   = 48;
	localparam int LOG2_W   = 5;
	localparam int CIDX_W   = 2;

	localparam logic [CNT_W-1:0] COUNT_MAX = 11'd2047;

	localparam logic [LOG2_W-1:0] LOG2_RESET  = 5'd3;
	localparam logic [CNT_W-1:0]  LIMIT_RESET = 11'd1024;

	typedef enum logic [KIND_W-1:0] {
		KIND_ALLOC_ONE = 2'd0,
		KIND_ALLOC_RUN = 2'd1,
		KIND_FREE_ONE  = 2'd2,
		KIND_FREE_RUN  = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_NO_SPACE  = 2'd1,
		ST_BAD_FREE  = 2'd2,
		ST_UNUSED    = 2'd3
	} status_t;

	typedef enum logic [CIDX_W-1:0] {
		REG_POOL_BASE  = 2'd0,
		REG_OBJ_LOG2   = 2'd1,
		REG_SLOT_LIMIT = 2'd2,
		REG_NONE       = 2'd3
	} reg_idx_t;

	// Saturating add/subtract on the allocated count
	function automatic logic [CNT_W-1:0] count_update(input logic [CNT_W-1:0] a,
		input logic [CNT_W-1:0] b, input logic sub);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (sub) begin
			count_update = (b > a) ? '0 : a - b;
		end else begin
			count_update = (s > {1'b0, COUNT_MAX}) ? COUNT_MAX : s[CNT_W-1:0];
		end
	endfunction

endpackage

FILE: sv/fixed_slot_allocator_unit.sv
// Fixed-size slot allocator: tail bump, LIFO free list and allocated count.
//
// Input channel (in_valid/in_ready) carries kind, slot and count; output
// channel (out_valid/out_ready) returns status, given_slot, given_address
// and allocated_now, one result per input transfer.
// Configuration registers (pool_base, object_size_log2, slot_limit) are
// written through cfg_we/cfg_index/cfg_data. The user must write them only
// while the block is idle; the block itself does not enforce this.
// One item is worked at a time under a small sequencer; in_ready is high
// only when no item is in flight.
// An accepted item passes through EXEC and ADDR before out_valid rises; an
// allocation served from the free list adds POP (one registered read of
// the link memory), and a run free that does not end at the tail adds PUSH,
// which writes one link a cycle for each slot of the run.
// in_ready returns the cycle after the output transfer.
// If the receiver stalls, the result is held in its registers and no new
// item is taken until it is transferred.
// Reset empties the pool: tail and count at zero, free list empty, config
// at its defaults. The link memory is not cleared; entries are only read
// after being written by a push.
module fixed_slot_allocator_unit #(
	parameter int SLOTS = fsa_pkg::SLOTS_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_we,
	input  logic [fsa_pkg::CIDX_W-1:0]    cfg_index,
	input  logic [fsa_pkg::ADDR_W-1:0]    cfg_data,
	// request channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [fsa_pkg::KIND_W-1:0]    kind,
	input  logic [fsa_pkg::SLOT_W-1:0]    slot,
	input  logic [fsa_pkg::CNT_W-1:0]     count,
	// result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [fsa_pkg::STATUS_W-1:0]  status,
	output logic [fsa_pkg::CNT_W-1:0]     given_slot,
	output logic [fsa_pkg::ADDR_W-1:0]    given_address,
	output logic [fsa_pkg::CNT_W-1:0]     allocated_now
);
	import fsa_pkg::*;

`include "fixed_slot_allocator_unit_macros.svh"

	localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int LINK_W = $clog2(SLOTS + 1);
	localparam logic [31:0] SLOTS_W = 32'(SLOTS);
	localparam logic [LINK_W-1:0] HEAD_EMPTY = LINK_W'(SLOTS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_POP,
		S_PUSH,
		S_ADDR,
		S_OUT
	} state_t;

	state_t state_q;

	// configuration
	logic [ADDR_W-1:0] pool_base_q;
	logic [LOG2_W-1:0] obj_log2_q;
	logic [CNT_W-1:0]  slot_limit_q;

	// allocator state
	logic [CNT_W-1:0]  tail_q;
	logic [LINK_W-1:0] head_q;
	logic [CNT_W-1:0]  alloc_q;

	// latched request and working registers
	kind_t             kind_q;
	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  ptr_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  given_q;
	logic              hands_q;
	status_t           status_q;

	// result registers
	logic [STATUS_W-1:0] status_out_q;
	logic [CNT_W-1:0]    given_slot_q;
	logic [ADDR_W-1:0]   given_addr_q;
	logic [CNT_W-1:0]    alloc_out_q;
	logic                out_valid_q;

	// link memory
	logic [LINK_W-1:0] link_mem [SLOTS];
	logic [LINK_W-1:0] link_rd_q;
	logic              mem_we;
	logic              mem_re;
	logic [IDX_W-1:0]  mem_addr;

	// decode of the latched request
	logic [CNT_W-1:0] usable;
	logic [CNT_W:0]   tail_sum;
	logic [CNT_W:0]   run_end;
	logic             head_valid;
	logic             slot_in_mem;
	logic             ptr_in_mem;
	logic [CNT_W-1:0] slot_ext;
	kind_t            kind_in;

	// shared count unit
	logic [CNT_W-1:0] cnt_opnd;
	logic             cnt_sub;
	logic [CNT_W-1:0] cnt_next;

	assign usable      = (32'(slot_limit_q) < SLOTS_W) ? slot_limit_q : CNT_W'(SLOTS);
	assign slot_ext    = CNT_W'(slot_q);
	assign tail_sum    = {1'b0, tail_q} + {1'b0, (kind_q == KIND_ALLOC_RUN) ? count_q : 11'd1};
	assign run_end     = {1'b0, slot_ext} + {1'b0, count_q};
	assign head_valid  = 32'(head_q) < SLOTS_W;
	assign slot_in_mem = 32'(slot_ext) < SLOTS_W;
	assign ptr_in_mem  = 32'(ptr_q) < SLOTS_W;

	// a run of one is a single allocation
	assign kind_in = (kind_t'(kind) == KIND_ALLOC_RUN && count == 11'd1) ?
		KIND_ALLOC_ONE : kind_t'(kind);

	assign cnt_sub  = (kind_q == KIND_FREE_ONE) || (kind_q == KIND_FREE_RUN);
	assign cnt_opnd = (kind_q == KIND_ALLOC_ONE || kind_q == KIND_FREE_ONE) ? 11'd1 : count_q;
	assign cnt_next = count_update(alloc_q, cnt_opnd, cnt_sub);

	// link memory port control
	always_comb begin
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		mem_addr = IDX_W'(head_q);
		case (state_q)
			S_EXEC: begin
				if (kind_q == KIND_ALLOC_ONE && head_valid) begin
					mem_re   = 1'b1;
					mem_addr = IDX_W'(head_q);
				end else if (kind_q == KIND_FREE_ONE && {1'b0, slot_ext} < {1'b0, tail_q}) begin
					mem_we   = slot_in_mem;
					mem_addr = IDX_W'(slot_ext);
				end
			end
			S_PUSH: begin
				mem_we   = ptr_in_mem;
				mem_addr = IDX_W'(ptr_q);
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// link memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			link_mem[mem_addr] <= head_q;
		end
		if (mem_re) begin
			link_rd_q <= link_mem[mem_addr];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q  <= '0;
			obj_log2_q   <= LOG2_RESET;
			slot_limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_POOL_BASE:  pool_base_q  <= cfg_data;
				REG_OBJ_LOG2:   obj_log2_q   <= cfg_data[LOG2_W-1:0];
				REG_SLOT_LIMIT: slot_limit_q <= cfg_data[CNT_W-1:0];
				default:        ;
			endcase
		end
	end

	// sequencer, allocator state and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			tail_q       <= '0;
			head_q       <= HEAD_EMPTY;
			alloc_q      <= '0;
			out_valid_q  <= 1'b0;
			kind_q       <= KIND_ALLOC_ONE;
			slot_q       <= '0;
			count_q      <= '0;
			ptr_q        <= '0;
			rem_q        <= '0;
			given_q      <= '0;
			hands_q      <= 1'b0;
			status_q     <= ST_OK;
			status_out_q <= '0;
			given_slot_q <= '0;
			given_addr_q <= '0;
			alloc_out_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						kind_q  <= kind_in;
						slot_q  <= slot;
						count_q <= count;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					status_q <= ST_OK;
					hands_q  <= 1'b0;
					given_q  <= '0;
					state_q  <= S_ADDR;
					case (kind_q)
						KIND_ALLOC_ONE, KIND_ALLOC_RUN: begin
							if (kind_q == KIND_ALLOC_ONE && head_valid) begin
								// pop the free list; next head arrives from memory
								given_q <= CNT_W'(head_q);
								hands_q <= 1'b1;
								alloc_q <= cnt_next;
								state_q <= S_POP;
							end else if (tail_sum > {1'b0, usable}) begin
								status_q <= ST_NO_SPACE;
							end else begin
								given_q <= tail_q;
								hands_q <= 1'b1;
								tail_q  <= tail_sum[CNT_W-1:0];
								alloc_q <= cnt_next;
							end
						end
						KIND_FREE_ONE: begin
							if ({1'b0, slot_ext} >= {1'b0, tail_q}) begin
								status_q <= ST_BAD_FREE;
							end else begin
								if (slot_in_mem) begin
									head_q <= LINK_W'(slot_ext);
								end
								alloc_q <= cnt_next;
							end
						end
						default: begin
							// run free: reject a run past the tail, else lower the tail or push slot by slot
							if (run_end > {1'b0, tail_q}) begin
								status_q <= ST_BAD_FREE;
							end else if (run_end == {1'b0, tail_q}) begin
								tail_q  <= slot_ext;
								alloc_q <= cnt_next;
							end else begin
								alloc_q <= cnt_next;
								ptr_q   <= slot_ext;
								rem_q   <= count_q;
								if (count_q != '0) begin
									state_q <= S_PUSH;
								end
							end
						end
					endcase
				end
				S_POP: begin
					head_q  <= link_rd_q;
					state_q <= S_ADDR;
				end
				S_PUSH: begin
					if (ptr_in_mem) begin
						head_q <= LINK_W'(ptr_q);
					end
					ptr_q <= ptr_q + 11'd1;
					rem_q <= rem_q - 11'd1;
					if (rem_q == 11'd1) begin
						state_q <= S_ADDR;
					end
				end
				S_ADDR: begin
					status_out_q <= status_q;
					alloc_out_q  <= alloc_q;
					if (hands_q) begin
						given_slot_q <= given_q;
						given_addr_q <= pool_base_q + (ADDR_W'(given_q) << obj_log2_q);
					end else begin
						given_slot_q <= '0;
						given_addr_q <= '0;
					end
					out_valid_q <= 1'b1;
					state_q     <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready      = (state_q == S_IDLE);
	assign out_valid     = out_valid_q;
	assign status        = status_out_q;
	assign given_slot    = given_slot_q;
	assign given_address = given_addr_q;
	assign allocated_now = alloc_out_q;

	// checks
	`FSA_ASSERT_IMP(a_one_in_flight, clk, arst_n, in_ready, !out_valid, "result pending while ready")
	`FSA_ASSERT_NXT(a_busy_after_take, clk, arst_n, in_valid && in_ready, !in_ready, "ready after transfer")
	`FSA_ASSERT_IMP(a_fail_no_handout, clk, arst_n, out_valid && status != ST_OK, given_slot == '0 && given_address == '0, "failed op hands out a slot")

endmodule
